### rtl/core/gbwc_pkg.sv
// ----------------------------------------------------------------------------
// gbwc_pkg
// Shared types, codes and conversion functions of the GB2312 width converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gbwc_pkg;

   // byte codes
   localparam logic [7:0] HIGH_BIT_CODE   = 8'h80;
   localparam logic [7:0] SPACE_CODE      = 8'h20;
   localparam logic [7:0] DOLLAR_CODE     = 8'h24;
   localparam logic [7:0] TILDE_CODE      = 8'h7e;
   localparam logic [7:0] DELETE_CODE     = 8'h7f;
   localparam logic [7:0] SYMBOL_LEAD     = 8'ha1;
   localparam logic [7:0] ALNUM_LEAD      = 8'ha3;
   localparam logic [7:0] FW_DOLLAR_TRAIL = 8'he7;
   localparam logic [7:0] FW_TILDE_TRAIL  = 8'hab;
   localparam logic [7:0] FW_YUAN_TRAIL   = 8'ha4;
   localparam logic [7:0] FW_LAST_TRAIL   = 8'hfd;

   // direction register values
   localparam logic DIR_WIDEN  = 1'b0;
   localparam logic DIR_NARROW = 1'b1;

   // up to three result bytes caused by one input byte
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            string_end;
   } bundle_type;

   function automatic bundle_type push(bundle_type b, logic [7:0] v);
      bundle_type r;
      r = b;
      unique case (b.count)
         2'd0: begin
            r.bytes[0] = v;
            r.count    = 2'd1;
         end
         2'd1: begin
            r.bytes[1] = v;
            r.count    = 2'd2;
         end
         2'd2: begin
            r.bytes[2] = v;
            r.count    = 2'd3;
         end
         default: r = b;
      endcase
      return r;
   endfunction

   // ASCII byte to full-width form
   function automatic bundle_type widen_low(bundle_type b, logic [7:0] c);
      bundle_type r;
      r = b;
      if (c < SPACE_CODE || c == DELETE_CODE) begin
         r = push(r, c);
      end else if (c == SPACE_CODE) begin
         r = push(r, SYMBOL_LEAD);
         r = push(r, SYMBOL_LEAD);
      end else if (c == DOLLAR_CODE) begin
         r = push(r, SYMBOL_LEAD);
         r = push(r, FW_DOLLAR_TRAIL);
      end else if (c == TILDE_CODE) begin
         r = push(r, SYMBOL_LEAD);
         r = push(r, FW_TILDE_TRAIL);
      end else begin
         r = push(r, ALNUM_LEAD);
         r = push(r, c + HIGH_BIT_CODE);
      end
      return r;
   endfunction

   // full-width pair back to ASCII, other pairs unchanged
   function automatic bundle_type narrow_pair(bundle_type b, logic [7:0] c,
                                              logic [7:0] d);
      bundle_type r;
      r = b;
      if (c == SYMBOL_LEAD && d == SYMBOL_LEAD) begin
         r = push(r, SPACE_CODE);
      end else if (c == SYMBOL_LEAD && d == FW_DOLLAR_TRAIL) begin
         r = push(r, DOLLAR_CODE);
      end else if (c == SYMBOL_LEAD && d == FW_TILDE_TRAIL) begin
         r = push(r, TILDE_CODE);
      end else if (c != ALNUM_LEAD || d < SYMBOL_LEAD || d > FW_LAST_TRAIL ||
                   d == FW_YUAN_TRAIL) begin
         r = push(r, c);
         r = push(r, d);
      end else begin
         r = push(r, d - HIGH_BIT_CODE);
      end
      return r;
   endfunction

   // all results of one input byte
   function automatic bundle_type convert(logic holding, logic [7:0] held,
                                          logic [7:0] c, logic last, logic dir);
      bundle_type r;
      r = '0;
      if (holding) begin
         if (c[7]) begin
            if (dir == DIR_WIDEN) begin
               r = push(r, held);
               r = push(r, c);
            end else begin
               r = narrow_pair(r, held, c);
            end
         end else begin
            r = push(r, held);
            if (dir == DIR_WIDEN) begin
               r = widen_low(r, c);
            end else begin
               r = push(r, c);
            end
         end
      end else if (c[7]) begin
         if (last) begin
            r = push(r, c);
         end
      end else if (dir == DIR_WIDEN) begin
         r = widen_low(r, c);
      end else begin
         r = push(r, c);
      end
      r.string_end = last;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/gbwc_emitter.sv
// ----------------------------------------------------------------------------
// gbwc_emitter
// Holds one result bundle and sends its bytes one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gbwc_emitter (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  gbwc_pkg::bundle_type    bundle,
   output logic                    can_load,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_end,
   output logic                    rsp_string_end
);
   import gbwc_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   bundle_type bundle_ff, bundle_in;
   logic       at_end;
   logic       sent;

   assign at_end   = (idx_ff == bundle_ff.count - 2'd1);
   assign sent     = valid_ff && rsp_ready;
   assign can_load = !valid_ff || (sent && at_end);

   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (load) begin
         valid_in  = 1'b1;
         idx_in    = 2'd0;
         bundle_in = bundle;
      end else if (sent) begin
         if (at_end) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bundle_ff <= bundle_in;
   end

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_out_byte = bundle_ff.bytes[0];
         2'd1:    rsp_out_byte = bundle_ff.bytes[1];
         default: rsp_out_byte = bundle_ff.bytes[2];
      endcase
   end

   assign rsp_valid      = valid_ff;
   assign rsp_run_end    = at_end;
   assign rsp_string_end = at_end && bundle_ff.string_end;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bundle_ff.count != 2'd0)
      else $error("emitter holds an empty bundle");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < bundle_ff.count)
      else $error("emitter index past bundle end");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && idx_ff == 2'd0)
      else $error("loaded bundle does not start at first byte");

endmodule

`default_nettype wire

### rtl/core/gb2312_width_converter_unit.sv
// ----------------------------------------------------------------------------
// gb2312_width_converter_unit
// ASCII <-> GB2312 full-width byte-stream converter.
// ----------------------------------------------------------------------------
// Output: first result byte is valid the cycle after the input transfer.
// Throughput: one input byte per cycle while rsp_ready is high and each
//   input yields one result; an input yielding more (up to 3) holds the
//   single-entry result bundle register until its last byte is sent.
// Reset: synchronous, active high; clears direction, the lead-byte holding
//   flag and result valid. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2312_width_converter_unit (
   input  wire        clock,
   input  wire        reset,
   // input byte channel
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_in_byte,
   input  wire        req_last,
   // result byte channel
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end,
   // direction register write
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_direction
);
   import gbwc_pkg::*;

   // direction register: 0 widens ASCII, 1 narrows full-width pairs
   logic       dir_ff, dir_in;
   // pending lead byte (any byte with the top bit set)
   logic       holding_ff, holding_in;
   logic [7:0] held_ff, held_in;

   logic       accept;
   logic       can_load;
   bundle_type bundle;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // an input is taken whenever the emitter can take its bundle this cycle
   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   // all result bytes of this input, computed in one pass
   assign bundle = convert(holding_ff, held_ff, req_in_byte, req_last, dir_ff);

   always_comb begin
      dir_in     = dir_ff;
      holding_in = holding_ff;
      held_in    = held_ff;
      if (csr_valid) begin
         dir_in = csr_direction;
      end
      if (accept) begin
         // a high byte starts a new pending lead unless it closes a pair
         // or ends the string
         holding_in = !holding_ff && req_in_byte[7] && !req_last;
         held_in    = req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= DIR_WIDEN;
         holding_ff <= 1'b0;
      end else begin
         dir_ff     <= dir_in;
         holding_ff <= holding_in;
      end
      held_ff <= held_in;
   end

   // bundles with no bytes (lead byte only held) are not loaded
   gbwc_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load           (accept && bundle.count != 2'd0),
      .bundle         (bundle),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   a_held_is_high: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> held_ff[7])
      else $error("held lead byte below 0x80");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> !holding_ff)
      else $error("lead byte still held after end of string");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

endmodule

`default_nettype wire
